// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the biquad RTL.
// Bodies vanish when SYNTHESIS is defined; users need clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");
`define ASSERT_IMPLY(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> post) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, prop)
`define ASSERT_IMPLY(lbl, pre, post)
`endif
`endif

// ===== rtl/bq_pkg.sv =====
// Package for the biquad filter: default sizes, register indexes,
// microcode word type and the microcode program. No dependencies.
`default_nettype none

package bq_pkg;

	localparam int SAMPLE_BITS_DEF = 24;
	localparam int COEF_BITS_DEF   = 32;
	localparam int STATE_BITS_DEF  = 40;

	localparam int NUM_COEF  = 5;
	localparam int CFG_IDX_W = 3;
	localparam int PC_W      = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		COEF_B0 = 3'd0,
		COEF_B1 = 3'd1,
		COEF_B2 = 3'd2,
		COEF_A1 = 3'd3,
		COEF_A2 = 3'd4
	} coef_sel_t;

	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_LD_D1,
		ACC_ADD,
		ACC_LD_D2,
		ACC_SUB,
		ACC_LD_PROD
	} acc_op_t;

	typedef enum logic [1:0] {
		SEQ_NEXT,
		SEQ_WAIT_IN,
		SEQ_WAIT_OUT,
		SEQ_JUMP
	} seq_t;

	typedef enum logic {
		MUL_X,
		MUL_Y
	} mul_src_t;

	typedef struct packed {
		seq_t            seq;
		logic [PC_W-1:0] target;
		coef_sel_t       coef;
		mul_src_t        src;
		acc_op_t         acc;
		logic            y_wr;
		logic            out_wr;
		logic            d1_wr;
		logic            d2_wr;
		logic            clr;
	} uop_t;

	localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
	localparam logic [PC_W-1:0] PC_B0   = 4'd1;
	localparam logic [PC_W-1:0] PC_B1   = 4'd2;
	localparam logic [PC_W-1:0] PC_Y    = 4'd3;
	localparam logic [PC_W-1:0] PC_OUT  = 4'd4;
	localparam logic [PC_W-1:0] PC_D1A  = 4'd5;
	localparam logic [PC_W-1:0] PC_D1   = 4'd6;
	localparam logic [PC_W-1:0] PC_D2A  = 4'd7;
	localparam logic [PC_W-1:0] PC_D2   = 4'd8;
	localparam logic [PC_W-1:0] PC_CLR  = 4'd9;

	function automatic uop_t microcode(input logic [PC_W-1:0] pc);
		uop_t u;
		u = '{seq: SEQ_NEXT, target: PC_IDLE, coef: COEF_B0, src: MUL_X, acc: ACC_HOLD,
			y_wr: 1'b0, out_wr: 1'b0, d1_wr: 1'b0, d2_wr: 1'b0, clr: 1'b0};
		case (pc)
			PC_IDLE: begin
				u.seq    = SEQ_WAIT_IN;
				u.target = PC_CLR;
			end
			PC_B0: begin
				u.coef = COEF_B0;
				u.acc  = ACC_LD_D1;
			end
			PC_B1: begin
				u.coef = COEF_B1;
				u.acc  = ACC_ADD;
			end
			PC_Y: begin
				u.y_wr = 1'b1;
				u.acc  = ACC_LD_D2;
			end
			PC_OUT: begin
				u.seq    = SEQ_WAIT_OUT;
				u.coef   = COEF_A1;
				u.src    = MUL_Y;
				u.out_wr = 1'b1;
			end
			PC_D1A: begin
				u.coef = COEF_B2;
				u.acc  = ACC_SUB;
			end
			PC_D1: begin
				u.coef  = COEF_A2;
				u.src   = MUL_Y;
				u.acc   = ACC_LD_PROD;
				u.d1_wr = 1'b1;
			end
			PC_D2A: begin
				u.acc = ACC_SUB;
			end
			PC_D2: begin
				u.seq   = SEQ_JUMP;
				u.d2_wr = 1'b1;
			end
			PC_CLR: begin
				u.seq = SEQ_JUMP;
				u.clr = 1'b1;
			end
			default: begin
				u.seq = SEQ_JUMP;
			end
		endcase
		return u;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/biquad_tdf2_filter.sv =====
// Biquad section, transposed direct form II, run by a microcoded sequencer.
// Depends on bq_pkg and assert_macros.svh.
//
//   channel  direction  handshake            payload
//   in       into       in_valid / in_stall  command, sample_in
//   out      out of     out_valid/ out_stall sample_out, clipped
//   cfg      into       cfg_write            cfg_index, cfg_data
//
// After a filter transfer the program steps through B0 to D2 before it takes the
// next input; the result reaches the output register at step OUT, after B0, B1, Y.
// A clear runs the clear step. One shared multiplier, one product per microcode step.
// Reset restores the coefficients (b0 = 1.0) and zeroes both delay words.
// A full output register holds the program at its output step until it drains.
`default_nettype none
`include "assert_macros.svh"

module biquad_tdf2_filter
	import bq_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int COEF_BITS   = COEF_BITS_DEF,
	parameter int STATE_BITS  = STATE_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire                          command,
	input  wire  signed [SAMPLE_BITS-1:0] sample_in,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	output logic                         clipped,
	input  wire                          cfg_write,
	input  wire         [CFG_IDX_W-1:0]   cfg_index,
	input  wire         [COEF_BITS-1:0]   cfg_data
);

	localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
	localparam int DSH    = SAMPLE_BITS + COEF_BITS - STATE_BITS + 2;
	localparam int DSH_L  = (DSH > 0) ? DSH : 0;
	localparam int DSH_R  = (DSH < 0) ? -DSH : 0;
	localparam int RND_L  = (DSH_L > 0) ? DSH_L - 1 : 0;
	localparam int RND_R  = (DSH_R > 0) ? DSH_R - 1 : 0;
	localparam int TOP_W  = (PROD_W > STATE_BITS + DSH_L) ? PROD_W : STATE_BITS + DSH_L;
	localparam int ACC_W  = TOP_W + 3;
	localparam int ST_W   = ACC_W + DSH_R;
	localparam int YSH    = COEF_BITS - 6;

	localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << (COEF_BITS - 6);
	localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [STATE_BITS-1:0] STA_MAX = {1'b0, {(STATE_BITS-1){1'b1}}};
	localparam logic signed [STATE_BITS-1:0] STA_MIN = {1'b1, {(STATE_BITS-1){1'b0}}};

	logic [PC_W-1:0]               pc_q, pc_d;
	uop_t                          uop;
	logic                          in_xfer, out_free, go;
	logic signed [COEF_BITS-1:0]   coef_q [NUM_COEF];
	logic signed [SAMPLE_BITS-1:0] x_q, y_q, mul_b, y_d;
	logic signed [COEF_BITS-1:0]   mul_a;
	logic signed [PROD_W-1:0]      prod_q, prod_d;
	logic signed [ACC_W-1:0]       acc_q, acc_d, prod_ext, y_r;
	logic signed [ACC_W-1:0]       d1_term, d2_term;
	logic signed [ST_W-1:0]        s_e, s_r;
	logic signed [STATE_BITS-1:0]  d1_q, d2_q, st_d;
	logic                          clip_q, clip_d;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;
	logic                          clipped_q;

	function automatic logic signed [ACC_W-1:0] delay_term(input logic signed [STATE_BITS-1:0] d);
		logic signed [ACC_W-1:0] e;
		e = ACC_W'(d);
		if (DSH_R > 0) begin
			e = (e + signed'(ACC_W'(1) << RND_R)) >>> DSH_R;
		end else begin
			e = e <<< DSH_L;
		end
		return e;
	endfunction

	assign uop      = microcode(pc_q);
	assign in_stall = (pc_q != PC_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign go       = (uop.seq != SEQ_WAIT_OUT) || out_free;

	always_comb begin
		pc_d = pc_q + PC_W'(1);
		case (uop.seq)
			SEQ_NEXT: begin
				pc_d = pc_q + PC_W'(1);
			end
			SEQ_WAIT_IN: begin
				if (!in_xfer) begin
					pc_d = pc_q;
				end else if (command) begin
					pc_d = uop.target;
				end
			end
			SEQ_WAIT_OUT: begin
				if (!out_free) begin
					pc_d = pc_q;
				end
			end
			SEQ_JUMP: begin
				pc_d = uop.target;
			end
			default: begin
				pc_d = PC_IDLE;
			end
		endcase
	end

	// datapath
	always_comb begin
		mul_a    = coef_q[uop.coef];
		mul_b    = (uop.src == MUL_Y) ? y_q : x_q;
		prod_d   = mul_a * mul_b;
		prod_ext = ACC_W'(prod_q);
		d1_term  = delay_term(d1_q);
		d2_term  = delay_term(d2_q);

		case (uop.acc)
			ACC_LD_D1:   acc_d = d1_term;
			ACC_ADD:     acc_d = acc_q + prod_ext;
			ACC_LD_D2:   acc_d = d2_term + prod_ext;
			ACC_SUB:     acc_d = acc_q - prod_ext;
			ACC_LD_PROD: acc_d = prod_ext;
			default:     acc_d = acc_q;
		endcase

		y_r = (acc_q + signed'(ACC_W'(1) << (YSH - 1))) >>> YSH;
		if ((y_r[ACC_W-1:SAMPLE_BITS-1] == '0) || (y_r[ACC_W-1:SAMPLE_BITS-1] == '1)) begin
			y_d    = y_r[SAMPLE_BITS-1:0];
			clip_d = 1'b0;
		end else begin
			y_d    = y_r[ACC_W-1] ? SMP_MIN : SMP_MAX;
			clip_d = 1'b1;
		end

		s_e = ST_W'(acc_q);
		if (DSH_L > 0) begin
			s_r = (s_e + signed'(ST_W'(1) << RND_L)) >>> DSH_L;
		end else begin
			s_r = s_e <<< DSH_R;
		end
		if ((s_r[ST_W-1:STATE_BITS-1] == '0) || (s_r[ST_W-1:STATE_BITS-1] == '1)) begin
			st_d = s_r[STATE_BITS-1:0];
		end else begin
			st_d = s_r[ST_W-1] ? STA_MIN : STA_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= PC_IDLE;
			out_valid_q <= 1'b0;
			d1_q        <= '0;
			d2_q        <= '0;
			for (int i = 0; i < NUM_COEF; i++) begin
				coef_q[i] <= (i == 0) ? COEF_ONE : '0;
			end
		end else begin
			pc_q <= pc_d;
			if (uop.out_wr && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (uop.clr) begin
				d1_q <= '0;
				d2_q <= '0;
			end else begin
				if (uop.d1_wr) begin
					d1_q <= st_d;
				end
				if (uop.d2_wr) begin
					d2_q <= st_d;
				end
			end
			if (cfg_write && (cfg_index < CFG_IDX_W'(NUM_COEF))) begin
				coef_q[cfg_index] <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			x_q <= sample_in;
		end
		if (go) begin
			prod_q <= prod_d;
			acc_q  <= acc_d;
		end
		if (uop.y_wr) begin
			y_q    <= y_d;
			clip_q <= clip_d;
		end
		if (uop.out_wr && out_free) begin
			sample_out_q <= y_q;
			clipped_q    <= clip_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign clipped    = clipped_q;

	`ASSERT_IMPLY(a_clear_zeroes, in_xfer && command, ##2 ((d1_q == '0) && (d2_q == '0)))
	`ASSERT_IMPLY(a_filter_starts, in_xfer && !command, ##1 (pc_q == PC_B0))
	`ASSERT_IMPLY(a_out_from_step, $rose(out_valid_q), $past(pc_q) == PC_OUT)
	`ASSERT_IMPLY(a_clip_extreme, out_valid_q && clipped_q, (sample_out_q == SMP_MAX) || (sample_out_q == SMP_MIN))

endmodule

`default_nettype wire
